>>> src/scpu_pkg.sv
// Package for the stack machine instruction step block.
// Holds request/response types, opcodes, fault codes and stack sizing.
// No dependencies.
package scpu_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DEPTH_W     = 5;

	localparam logic [15:0] PC_WRAP = 16'hFFFF;

	localparam logic [7:0] OP_PUSH   = 8'h01;
	localparam logic [7:0] OP_EMIT   = 8'h02;
	localparam logic [7:0] OP_WAIT   = 8'h03;
	localparam logic [7:0] OP_JMP    = 8'h04;
	localparam logic [7:0] OP_SUB    = 8'h07;
	localparam logic [7:0] OP_JMP_GT = 8'h08;
	localparam logic [7:0] OP_HALT   = 8'hFF;

	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_PUSH  = 3'd1;
	localparam logic [2:0] FAULT_SET   = 3'd2;
	localparam logic [2:0] FAULT_SUB   = 3'd3;
	localparam logic [2:0] FAULT_TEST  = 3'd4;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
	} scpu_req_t;

	typedef struct packed {
		logic [15:0]        next_address;
		logic               io_valid;
		logic [7:0]         io_id;
		logic [15:0]        io_value;
		logic [2:0]         fault;
		logic [DEPTH_W-1:0] depth;
	} scpu_rsp_t;

endpackage

>>> src/stack_cpu_instruction_step_top.sv
// Instruction step of a 16-bit stack machine: one request in, one response out.
// Holds program counter, stack depth and a shifting stack. Depends on scpu_pkg.
//
// One instruction per clock, sustained while the response side keeps up. A request
// lands in an input register, is executed from there against the program counter
// and the stack (top two entries read at fixed places of a shift stack) once the
// output register is free or being drained, and its response is held in that register.
// A new request is taken every cycle while the response side keeps up.
module stack_cpu_instruction_step_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  scpu_pkg::scpu_req_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output scpu_pkg::scpu_rsp_t out_data
);

	localparam int DW = scpu_pkg::DEPTH_W;
	localparam int SD = scpu_pkg::STACK_DEPTH;

	scpu_pkg::scpu_req_t req_s1;
	logic                req_valid_s1;
	scpu_pkg::scpu_rsp_t rsp_q;
	logic                out_valid_q;
	logic [15:0]         pc_q;
	logic [DW-1:0]       sp_q;
	logic [15:0]         stk_q [SD];

	logic                advance;
	logic [15:0]         pc_cur;
	logic [15:0]         pc_nxt;
	logic [15:0]         imm;
	logic [DW-1:0]       sp_nxt;
	logic [15:0]         stk_nxt [SD];
	logic                stack_full;
	scpu_pkg::scpu_rsp_t rsp_nxt;

	assign advance   = req_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !req_valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	assign imm        = {req_s1.first_byte, req_s1.second_byte};
	assign pc_cur     = (pc_q == scpu_pkg::PC_WRAP) ? 16'd0 : pc_q;
	assign stack_full = (sp_q == DW'(SD));

	always_comb begin
		pc_nxt  = pc_cur + 16'd1;
		sp_nxt  = sp_q;
		stk_nxt = stk_q;
		rsp_nxt = '0;
		case (req_s1.opcode)
			scpu_pkg::OP_PUSH: begin
				pc_nxt = pc_cur + 16'd3;
				if (stack_full) begin
					rsp_nxt.fault = scpu_pkg::FAULT_PUSH;
				end else begin
					for (int i = 1; i < SD; i++) begin
						stk_nxt[i] = stk_q[i-1];
					end
					sp_nxt = sp_q + DW'(1);
				end
				stk_nxt[0] = imm;
			end
			scpu_pkg::OP_EMIT: begin
				pc_nxt = pc_cur + 16'd2;
				rsp_nxt.io_valid = 1'b1;
				rsp_nxt.io_id    = req_s1.first_byte;
				if (sp_q != '0) begin
					rsp_nxt.io_value = stk_q[0];
					for (int i = 0; i < SD - 1; i++) begin
						stk_nxt[i] = stk_q[i+1];
					end
					sp_nxt = sp_q - DW'(1);
				end else begin
					rsp_nxt.fault = scpu_pkg::FAULT_SET;
				end
			end
			scpu_pkg::OP_JMP: begin
				pc_nxt = imm;
			end
			scpu_pkg::OP_SUB: begin
				if (sp_q >= DW'(2)) begin
					stk_nxt[0] = stk_q[1] - stk_q[0];
					for (int i = 1; i < SD - 1; i++) begin
						stk_nxt[i] = stk_q[i+1];
					end
					sp_nxt = sp_q - DW'(1);
				end else begin
					rsp_nxt.fault = scpu_pkg::FAULT_SUB;
				end
			end
			scpu_pkg::OP_JMP_GT: begin
				pc_nxt = pc_cur + 16'd3;
				if (sp_q != '0) begin
					if (stk_q[0] != 16'd0 && !stk_q[0][15]) begin
						pc_nxt = imm;
					end
					for (int i = 0; i < SD - 1; i++) begin
						stk_nxt[i] = stk_q[i+1];
					end
					sp_nxt = sp_q - DW'(1);
				end else begin
					rsp_nxt.fault = scpu_pkg::FAULT_TEST;
				end
			end
			scpu_pkg::OP_WAIT, scpu_pkg::OP_HALT: begin
				pc_nxt = pc_cur + 16'd1;
			end
			default: begin
				pc_nxt = pc_cur + 16'd1;
			end
		endcase
		rsp_nxt.next_address = (pc_nxt == scpu_pkg::PC_WRAP) ? 16'd0 : pc_nxt;
		rsp_nxt.depth        = sp_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			pc_q         <= '0;
			sp_q         <= '0;
		end else begin
			if (in_ready) begin
				req_valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				pc_q        <= pc_nxt;
				sp_q        <= sp_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (advance) begin
			rsp_q <= rsp_nxt;
			stk_q <= stk_nxt;
		end
	end

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.depth <= DW'(SD)))
		else $error("stack depth above capacity");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.fault == scpu_pkg::FAULT_PUSH) |-> (out_data.depth == DW'(SD)))
		else $error("push overflow without full stack");

	a_io_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.io_valid) |->
		(out_data.fault == scpu_pkg::FAULT_NONE || out_data.fault == scpu_pkg::FAULT_SET))
		else $error("output write with unrelated fault");

	a_io_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.io_valid) |->
		(out_data.io_id == 8'd0 && out_data.io_value == 16'd0))
		else $error("output write fields set without write");

	a_addr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.next_address != scpu_pkg::PC_WRAP))
		else $error("next address not wrapped");

endmodule
